// File: rtl/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types and constants for the mosaic pixelation stream block.
// ----------------------------------------------------------------------------
package mps_pkg;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;

   localparam int PIX_W    = 24;   // blue, green, red
   localparam int SIZE_W   = 12;   // frame_width / frame_height registers
   localparam int AMT_W    = 17;   // Q1.16 amounts
   localparam int TILE_W   = 11;   // latched tile size and phase counters
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 17;

   // tile = floor(size * amount / (5 * 65536))
   localparam int TILE_DIV  = 5 * 65536;
   localparam int FRAC_BITS = 16;
   // floor(p / 5) == (p * 52429) >> 18 for p < 43690
   localparam int DIV5_W     = 16;
   localparam int DIV5_MUL   = 52429;
   localparam int DIV5_SHIFT = 18;

   localparam int RST_FRAME_WIDTH  = 640;
   localparam int RST_FRAME_HEIGHT = 480;
   localparam int RST_AMOUNT_X     = 32768;
   localparam int RST_AMOUNT_Y     = 32768;

   typedef logic [CSR_AW-1:0] csr_index_type;

   localparam csr_index_type REG_FRAME_WIDTH  = 2'd0;
   localparam csr_index_type REG_FRAME_HEIGHT = 2'd1;
   localparam csr_index_type REG_AMOUNT_X     = 2'd2;
   localparam csr_index_type REG_AMOUNT_Y     = 2'd3;

   typedef logic [PIX_W-1:0] pixel_type;

endpackage

// File: rtl/mps_line_store.sv
// ----------------------------------------------------------------------------
// mps_line_store
// One-line tile store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mps_line_store #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11,
   parameter int DW    = 24
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read-before-write on a same-address collision; the caller bypasses that case
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mosaic_pixelate_stream_top.sv
// ----------------------------------------------------------------------------
// mosaic_pixelate_stream_top
// Mosaic pixelation of a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one pixel per clock while rsp_tready
// is high and no register write holds req_tready low; an accepted pixel goes
// through the stage 1 and response registers and is replaced by the top-left
// pixel of its mosaic tile. Tile size is floor(size * amount / 327680), at
// least 1, latched at frame_start and when the position wraps after the last
// pixel of a frame. The position counters and the line-store read run at the
// input handshake; the tile value is picked and written back in the second
// stage. The line store has separate read and write ports, so a read for the
// incoming pixel and a write-back from stage 1 share a cycle and a pixel can
// be taken every clock while rsp_tready is high.
// A register write takes the shared size*amount multiplier; req_tready is low
// while csr_valid or cfg_hold_ff is high, so the new tile size can settle.
module mosaic_pixelate_stream_top #(
   parameter int MAX_WIDTH  = mps_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mps_pkg::DEF_MAX_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request: tdata = {red, green, blue}, blue in the low bits
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mps_pkg::PIX_W-1:0]     req_tdata,
   input  logic [0:0]                    req_tuser,   // [0] frame_start
   // response: tdata = {red, green, blue}, blue in the low bits
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mps_pkg::PIX_W-1:0]     rsp_tdata,
   output logic                          rsp_tlast,   // frame_end
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  mps_pkg::csr_index_type        csr_addr,
   input  logic [mps_pkg::CSR_DW-1:0]    csr_wdata
);

   import mps_pkg::*;

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int PXW = WW + AMT_W;
   localparam int PYW = HW + AMT_W;
   localparam int QXW = PXW - FRAC_BITS;
   localparam int QYW = PYW - FRAC_BITS;

   localparam int RST_EFF_W = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
   localparam int RST_EFF_H = (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT;
   localparam int RST_PROD_X = RST_EFF_W * RST_AMOUNT_X;
   localparam int RST_PROD_Y = RST_EFF_H * RST_AMOUNT_Y;
   localparam int RST_TX_RAW = RST_PROD_X / TILE_DIV;
   localparam int RST_TY_RAW = RST_PROD_Y / TILE_DIV;
   localparam int RST_TX = ((RST_TX_RAW < 1) ? 1 : RST_TX_RAW) % (1 << TILE_W);
   localparam int RST_TY = ((RST_TY_RAW < 1) ? 1 : RST_TY_RAW) % (1 << TILE_W);

   // ---------------- configuration ----------------
   logic [WW-1:0]     eff_w_ff, eff_w_new;
   logic [HW-1:0]     eff_h_ff, eff_h_new;
   logic [AMT_W-1:0]  amount_x_ff, amount_y_ff;
   logic [PXW-1:0]    prod_x_ff, prod_x_in;
   logic [PYW-1:0]    prod_y_ff, prod_y_in;
   logic [WW-1:0]     mul_x_a;
   logic [AMT_W-1:0]  mul_x_b;
   logic [HW-1:0]     mul_y_a;
   logic [AMT_W-1:0]  mul_y_b;
   logic              csr_fire;
   logic              cfg_hold_ff;
   logic [SIZE_W-1:0] csr_size;
   logic [AMT_W-1:0]  csr_amount;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign csr_size   = csr_wdata[SIZE_W-1:0];
   assign csr_amount = csr_wdata[AMT_W-1:0];

   // zero is taken as one, anything above the maximum saturates
   always_comb begin
      if (csr_size == '0) begin
         eff_w_new = WW'(1);
         eff_h_new = HW'(1);
      end else begin
         eff_w_new = (32'(csr_size) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(csr_size);
         eff_h_new = (32'(csr_size) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(csr_size);
      end
   end

   // one multiplier per axis, shared between the size and the amount write
   assign mul_x_a   = (csr_addr == REG_FRAME_WIDTH) ? eff_w_new : eff_w_ff;
   assign mul_x_b   = (csr_addr == REG_AMOUNT_X) ? csr_amount : amount_x_ff;
   assign mul_y_a   = (csr_addr == REG_FRAME_HEIGHT) ? eff_h_new : eff_h_ff;
   assign mul_y_b   = (csr_addr == REG_AMOUNT_Y) ? csr_amount : amount_y_ff;
   assign prod_x_in = PXW'(mul_x_a) * PXW'(mul_x_b);
   assign prod_y_in = PYW'(mul_y_a) * PYW'(mul_y_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff    <= WW'(RST_EFF_W);
         eff_h_ff    <= HW'(RST_EFF_H);
         amount_x_ff <= AMT_W'(RST_AMOUNT_X);
         amount_y_ff <= AMT_W'(RST_AMOUNT_Y);
         prod_x_ff   <= PXW'(RST_PROD_X);
         prod_y_ff   <= PYW'(RST_PROD_Y);
         cfg_hold_ff <= 1'b0;
      end else begin
         cfg_hold_ff <= csr_fire;
         if (csr_fire) begin
            unique case (csr_addr)
               REG_FRAME_WIDTH: begin
                  eff_w_ff  <= eff_w_new;
                  prod_x_ff <= prod_x_in;
               end
               REG_FRAME_HEIGHT: begin
                  eff_h_ff  <= eff_h_new;
                  prod_y_ff <= prod_y_in;
               end
               REG_AMOUNT_X: begin
                  amount_x_ff <= csr_amount;
                  prod_x_ff   <= prod_x_in;
               end
               REG_AMOUNT_Y: begin
                  amount_y_ff <= csr_amount;
                  prod_y_ff   <= prod_y_in;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // ---------------- tile size candidates ----------------
   logic [QXW+DIV5_W-1:0] div_x_full;
   logic [QYW+DIV5_W-1:0] div_y_full;
   logic [31:0]           q_x, q_y;
   logic [TILE_W-1:0]     cand_x_in, cand_y_in, cand_x_ff, cand_y_ff;

   // >> 16 then / 5 via reciprocal
   assign div_x_full = (QXW+DIV5_W)'(prod_x_ff[PXW-1:FRAC_BITS]) * (QXW+DIV5_W)'(DIV5_MUL);
   assign div_y_full = (QYW+DIV5_W)'(prod_y_ff[PYW-1:FRAC_BITS]) * (QYW+DIV5_W)'(DIV5_MUL);
   assign q_x        = 32'(div_x_full >> DIV5_SHIFT);
   assign q_y        = 32'(div_y_full >> DIV5_SHIFT);
   assign cand_x_in  = (q_x == 32'd0) ? TILE_W'(1) : q_x[TILE_W-1:0];
   assign cand_y_in  = (q_y == 32'd0) ? TILE_W'(1) : q_y[TILE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_x_ff <= TILE_W'(RST_TX);
         cand_y_ff <= TILE_W'(RST_TY);
      end else begin
         cand_x_ff <= cand_x_in;
         cand_y_ff <= cand_y_in;
      end
   end

   // ---------------- handshake ----------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_load, s1_move, s1_ready, req_fire;

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_load;
   assign s1_ready   = !s1_valid_ff || out_load;
   assign req_tready = s1_ready && !csr_valid && !cfg_hold_ff;
   assign req_fire   = req_tvalid && req_tready;

   // ---------------- position tracking (at request accept) ----------------
   logic [CW-1:0]     col_cnt_ff, col_cnt_in, cc;
   logic [RW-1:0]     row_cnt_ff, row_cnt_in, rc;
   logic [TILE_W-1:0] col_ph_ff, col_ph_in, cp;
   logic [TILE_W-1:0] row_ph_ff, row_ph_in, rp;
   logic [TILE_W-1:0] tile_w_ff, tile_w_in, tw;
   logic [TILE_W-1:0] tile_h_ff, tile_h_in, th;
   logic              frame_start, last_col, last_row;

   assign frame_start = req_tuser[0];

   always_comb begin
      cc = frame_start ? '0 : col_cnt_ff;
      rc = frame_start ? '0 : row_cnt_ff;
      cp = frame_start ? '0 : col_ph_ff;
      rp = frame_start ? '0 : row_ph_ff;
      tw = frame_start ? cand_x_ff : tile_w_ff;
      th = frame_start ? cand_y_ff : tile_h_ff;

      last_col = (32'(cc) + 32'd1) >= 32'(eff_w_ff);
      last_row = (32'(rc) + 32'd1) >= 32'(eff_h_ff);

      col_cnt_in = cc;
      row_cnt_in = rc;
      col_ph_in  = cp;
      row_ph_in  = rp;
      tile_w_in  = tw;
      tile_h_in  = th;

      if (!last_col) begin
         col_cnt_in = cc + 1'b1;
         col_ph_in  = (({1'b0, cp} + 1'b1) >= {1'b0, tw}) ? '0 : cp + 1'b1;
      end else begin
         col_cnt_in = '0;
         col_ph_in  = '0;
         if (!last_row) begin
            row_cnt_in = rc + 1'b1;
            row_ph_in  = (({1'b0, rp} + 1'b1) >= {1'b0, th}) ? '0 : rp + 1'b1;
         end else begin
            // frame wraps: relatch the tile size
            row_cnt_in = '0;
            row_ph_in  = '0;
            tile_w_in  = cand_x_ff;
            tile_h_in  = cand_y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         col_ph_ff  <= '0;
         row_ph_ff  <= '0;
         tile_w_ff  <= TILE_W'(1);
         tile_h_ff  <= TILE_W'(1);
      end else if (req_fire) begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
         col_ph_ff  <= col_ph_in;
         row_ph_ff  <= row_ph_in;
         tile_w_ff  <= tile_w_in;
         tile_h_ff  <= tile_h_in;
      end
   end

   // ---------------- stage 1: tile value select ----------------
   pixel_type     s1_pix_ff, held_ff, value, rd_data;
   logic          s1_top_ff, s1_new_ff, s1_last_ff, s1_byp_ff, byp_in;
   logic [CW-1:0] s1_col_ff;
   logic          wr_en;

   assign wr_en  = s1_move && s1_top_ff;
   assign byp_in = wr_en && (s1_col_ff == cc);
   assign s1_valid_in = req_fire || (s1_valid_ff && !out_load);

   // a same-cycle write to the read column leaves that value in held_ff
   always_comb begin
      if (s1_top_ff) begin
         value = s1_new_ff ? s1_pix_ff : held_ff;
      end else begin
         value = s1_byp_ff ? held_ff : rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         held_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (wr_en) begin
            held_ff <= value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff  <= req_tdata;
         s1_top_ff  <= (rp == '0);
         s1_new_ff  <= (cp == '0);
         s1_last_ff <= last_col && last_row;
         s1_col_ff  <= cc;
         s1_byp_ff  <= byp_in;
      end
   end

   mps_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW),
      .DW    (PIX_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (value),
      .rd_en   (req_fire),
      .rd_addr (cc),
      .rd_data (rd_data)
   );

   // ---------------- response register ----------------
   pixel_type rsp_data_ff;
   logic      rsp_last_ff;

   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= value;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- assertions ----------------
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted request did not reach stage 1");

   a_cfg_settle: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> !req_tready)
      else $error("request taken before tile size settled");

   a_col_phase: assert property (@(posedge clock) disable iff (reset)
      (tile_w_ff != '0) |-> (col_ph_ff < tile_w_ff))
      else $error("column phase beyond tile width");

   a_row_phase: assert property (@(posedge clock) disable iff (reset)
      (tile_h_ff != '0) |-> (row_ph_ff < tile_h_ff))
      else $error("row phase beyond tile height");

   a_bypass_write: assert property (@(posedge clock) disable iff (reset)
      (req_fire && byp_in) |-> (s1_move && s1_top_ff))
      else $error("line store bypass without a write");

endmodule

// File: tb/tb_mosaic_pixelate_stream_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mosaic_pixelate_stream_top
// Self-checking bench for the mosaic pixelation stream block.
// ----------------------------------------------------------------------------
// Pixels are pushed through the request stream while a scoreboard tracks the
// frame position, tile phases and line store. It predicts each mosaic pixel
// and frame_end flag, and checks responses in order. Register sets change
// only with the pipeline empty. Both stream sides insert random gaps.
module tb_mosaic_pixelate_stream_top;
   import mps_pkg::*;

   localparam int LINE_DEPTH   = DEF_MAX_WIDTH;
   localparam int RANDOM_ITEMS = 380;
   localparam logic [AMT_W-1:0] AMOUNT_MAX = '1;
   localparam logic [AMT_W-1:0] AMOUNT_ONE = AMT_W'(65536);

   typedef struct {
      pixel_type pix;
      bit        frame_end;
   } mosaic_result_type;

   class mosaic_scoreboard_type;
      logic [SIZE_W-1:0] frame_width, frame_height;
      logic [AMT_W-1:0]  amount_x, amount_y;
      pixel_type         line_store [LINE_DEPTH];
      bit                line_written [LINE_DEPTH];
      pixel_type         held_pixel;
      logic [TILE_W-1:0] col_count, row_count, col_phase, row_phase;
      logic [TILE_W-1:0] tile_width, tile_height;
      mosaic_result_type expected_q [$];
      int                errors;

      function void clear();
         frame_width  = SIZE_W'(RST_FRAME_WIDTH);
         frame_height = SIZE_W'(RST_FRAME_HEIGHT);
         amount_x     = AMT_W'(RST_AMOUNT_X);
         amount_y     = AMT_W'(RST_AMOUNT_Y);
         foreach (line_written[i]) line_written[i] = 1'b0;
         held_pixel  = '0;
         col_count   = '0;
         row_count   = '0;
         col_phase   = '0;
         row_phase   = '0;
         tile_width  = TILE_W'(1);
         tile_height = TILE_W'(1);
         errors      = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DW-1:0] data);
         case (idx)
            REG_FRAME_WIDTH:  frame_width  = data[SIZE_W-1:0];
            REG_FRAME_HEIGHT: frame_height = data[SIZE_W-1:0];
            REG_AMOUNT_X:     amount_x     = data[AMT_W-1:0];
            REG_AMOUNT_Y:     amount_y     = data[AMT_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned limit);
         if (v == 0) return 1;
         if (32'(v) > limit) return limit;
         return 32'(v);
      endfunction

      function logic [TILE_W-1:0] tile_span(int unsigned size, logic [AMT_W-1:0] amount);
         longint unsigned t;
         t = (longint'(size) * longint'(amount)) / TILE_DIV;
         if (t < 1) t = 1;
         return t[TILE_W-1:0];
      endfunction

      function void latch_tiles();
         tile_width  = tile_span(eff_size(frame_width, DEF_MAX_WIDTH), amount_x);
         tile_height = tile_span(eff_size(frame_height, DEF_MAX_HEIGHT), amount_y);
      endfunction

      // true when the next pixel, without frame_start, would read a column
      // that no top tile row has filled yet
      function bit reads_unwritten();
         return (row_phase != 0) && !line_written[col_count];
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(pixel_type pix, bit frame_start);
         int unsigned w, h;
         pixel_type   value;
         bit          last_col, last_row;
         w = eff_size(frame_width, DEF_MAX_WIDTH);
         h = eff_size(frame_height, DEF_MAX_HEIGHT);
         if (frame_start) begin
            col_count = '0;
            row_count = '0;
            col_phase = '0;
            row_phase = '0;
            latch_tiles();
         end
         if (row_phase == 0) begin
            value = (col_phase == 0) ? pix : held_pixel;
            held_pixel = value;
            line_store[col_count]   = value;
            line_written[col_count] = 1'b1;
         end else begin
            value = line_store[col_count];
         end
         last_col = (int'(col_count) + 1 >= w);
         last_row = (int'(row_count) + 1 >= h);
         expected_q.push_back('{value, last_col && last_row});
         if (!last_col) begin
            col_count++;
            col_phase++;
            if (col_phase >= tile_width) col_phase = '0;
         end else begin
            col_count = '0;
            col_phase = '0;
            if (!last_row) begin
               row_count++;
               row_phase++;
               if (row_phase >= tile_height) row_phase = '0;
            end else begin
               row_count = '0;
               row_phase = '0;
               latch_tiles();
            end
         end
      endfunction

      function void check_response(pixel_type pix, bit frame_end);
         mosaic_result_type want;
         if (expected_q.size() == 0) begin
            $error("response with nothing pending: tdata=%h tlast=%b", pix, frame_end);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (pix[7:0] !== want.pix[7:0]) begin
            $error("blue_out: expected %0d, got %0d", want.pix[7:0], pix[7:0]);
            errors++;
         end
         if (pix[15:8] !== want.pix[15:8]) begin
            $error("green_out: expected %0d, got %0d", want.pix[15:8], pix[15:8]);
            errors++;
         end
         if (pix[23:16] !== want.pix[23:16]) begin
            $error("red_out: expected %0d, got %0d", want.pix[23:16], pix[23:16]);
            errors++;
         end
         if (frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, frame_end);
            errors++;
         end
      endfunction
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [PIX_W-1:0]     req_tdata  = '0;   // [7:0] blue, [15:8] green, [23:16] red
   logic [0:0]           req_tuser  = '0;   // [0] frame_start
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [PIX_W-1:0]     rsp_tdata;         // [7:0] blue, [15:8] green, [23:16] red
   logic                 rsp_tlast;         // frame_end
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_addr   = REG_FRAME_WIDTH;
   logic [CSR_DW-1:0]    csr_wdata  = '0;

   mosaic_scoreboard_type sb;
   bit rsp_stalls = 1'b1;
   int stall_left = 0;
   int stall_roll;

   mosaic_pixelate_stream_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // requests are noted before responses are checked, in one process
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata, req_tuser[0]);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tlast);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready = 1'b0;
      end else if (!rsp_stalls) begin
         rsp_tready = 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else begin
         rsp_tready = 1'b1;
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 20) stall_left = $urandom_range(1, 3);
         else if (stall_roll < 24) stall_left = $urandom_range(8, 40);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic pixel_type random_pixel();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 16) return '1;
      return pixel_type'($urandom());
   endfunction

   function automatic logic [SIZE_W-1:0] random_size(int unsigned span);
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return '0;
      if (r < 10) return SIZE_W'($urandom_range(DEF_MAX_WIDTH + 1, (1 << SIZE_W) - 1));
      return SIZE_W'($urandom_range(1, span));
   endfunction

   function automatic logic [AMT_W-1:0] random_amount();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return AMOUNT_ONE;
      if (r < 30) return AMOUNT_MAX;
      return AMT_W'($urandom_range(0, AMOUNT_MAX));
   endfunction

   // returns just after the accepting edge; valid stays up for the next call
   task automatic send_pixel(input pixel_type pix, input bit frame_start, input bit with_gaps);
      int gap;
      gap = with_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      if (sb.reads_unwritten()) frame_start = 1'b1;
      req_tvalid   = 1'b1;
      req_tdata    = pix;
      req_tuser[0] = frame_start;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_addr  = idx;
      csr_wdata = data;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      sb.set_register(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                            input logic [AMT_W-1:0] ax, input logic [AMT_W-1:0] ay);
      drain();
      write_csr(REG_FRAME_WIDTH, CSR_DW'(w));
      write_csr(REG_FRAME_HEIGHT, CSR_DW'(h));
      write_csr(REG_AMOUNT_X, ax);
      write_csr(REG_AMOUNT_Y, ay);
   endtask

   task automatic run_pixels(input int count, input bit start_frame, input bit with_gaps,
                             input bit pause_midway);
      bit fs;
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2) drain();
         fs = (i == 0 && start_frame) || ($urandom_range(0, 49) == 0);
         send_pixel(random_pixel(), fs, with_gaps);
      end
   endtask

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int sent;
      int phase;
      int n;
      sb = new;
      sb.clear();
      sent  = 0;
      phase = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset register values, tile size still 1x1 until a frame starts
      send_pixel(24'h000000, 1'b0, 1'b0);
      send_pixel(24'hFFFFFF, 1'b0, 1'b0);
      send_pixel(24'hA5C3F0, 1'b1, 1'b1);
      send_pixel(24'h5A3C0F, 1'b0, 1'b0);

      // zero sizes clamp to 1x1: every pixel closes a frame
      configure('0, '0, '0, '0);
      send_pixel(24'hFF00FF, 1'b0, 1'b1);
      send_pixel(24'h00FF00, 1'b1, 1'b0);
      send_pixel(24'h123456, 1'b0, 1'b0);
      send_pixel(24'hEDCBA9, 1'b1, 1'b1);

      // 2x2 tiles at full amount, second row comes from the line store
      configure(SIZE_W'(6), SIZE_W'(6), AMOUNT_MAX, AMOUNT_MAX);
      for (int i = 0; i < 14; i++) send_pixel(random_pixel(), i == 0, 1'b1);

      // oversize width saturates to the maximum line, back to back
      rsp_stalls = 1'b0;
      configure('1, '0, AMOUNT_MAX, AMOUNT_ONE);
      run_pixels(200, 1'b1, 1'b0, 1'b0);
      rsp_stalls = 1'b1;

      // tallest tiles
      configure(SIZE_W'(2), SIZE_W'(2048), '0, AMOUNT_MAX);
      run_pixels(80, 1'b1, 1'b1, 1'b0);
      configure(SIZE_W'(2048), SIZE_W'(2048), AMOUNT_ONE, AMOUNT_ONE);
      run_pixels(50, 1'b1, 1'b1, 1'b0);

      while (sent < RANDOM_ITEMS) begin
         configure(random_size(24), random_size(12), random_amount(), random_amount());
         n = $urandom_range(20, 90);
         rsp_stalls = ($urandom_range(0, 3) != 0);
         run_pixels(n, $urandom_range(0, 4) != 0, $urandom_range(0, 3) != 0, phase % 3 == 0);
         sent += n;
         phase++;
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
